// ===== src/shpmf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the sample histogram block: default widths and item mode codes.
// No dependencies.
package shpmf_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 10;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_FETCH = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

endpackage

// ===== src/shpmf_bin_ram.sv =====
`timescale 1ns / 1ps
// Bin count store: one write port, one read port, registered read data.
// Depends on shpmf_pkg for default widths.
module shpmf_bin_ram
    import shpmf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [SAMPLE_BITS-1:0] i_waddr,
    input  logic [COUNT_BITS-1:0]  i_wdata,
    input  logic [SAMPLE_BITS-1:0] i_raddr,
    output logic [COUNT_BITS-1:0]  o_rdata
);

    localparam int DEPTH = 1 << SAMPLE_BITS;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/shpmf_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the histogram: clearing sweep, read-modify-write of one bin, upward scan.
// Depends on shpmf_pkg; drives the ports of shpmf_bin_ram.
module shpmf_ctrl
    import shpmf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [1:0]             i_mode,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_bin_value,
    output logic [COUNT_BITS-1:0]  o_bin_count,
    output logic                   o_found,
    output logic                   o_we,
    output logic [SAMPLE_BITS-1:0] o_waddr,
    output logic [COUNT_BITS-1:0]  o_wdata,
    output logic [SAMPLE_BITS-1:0] o_raddr,
    input  logic [COUNT_BITS-1:0]  i_rdata
);

    localparam int PTR_BITS = SAMPLE_BITS + 1;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
    localparam logic [SAMPLE_BITS-1:0] LAST_BIN  = '1;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_ADD_WR, ST_SCAN} t_state;

    t_state                 r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [PTR_BITS-1:0]    r_ptr, n_ptr;
    logic [PTR_BITS-1:0]    r_scan, n_scan;
    logic [SAMPLE_BITS-1:0] r_add_addr, n_add_addr;
    logic                   r_valid, n_valid;
    logic                   r_found, n_found;
    logic [SAMPLE_BITS-1:0] r_bin_value, n_bin_value;
    logic [COUNT_BITS-1:0]  r_bin_count, n_bin_count;
    logic [PTR_BITS-1:0]    scan_next;
    logic                   accept;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign scan_next = r_scan + PTR_BITS'(1);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_ptr       = r_ptr;
        n_scan      = r_scan;
        n_add_addr  = r_add_addr;
        n_valid     = 1'b0;
        n_found     = r_found;
        n_bin_value = r_bin_value;
        n_bin_count = r_bin_count;
        o_we        = 1'b0;
        o_waddr     = r_clr_addr;
        o_wdata     = '0;
        o_raddr     = r_ptr[SAMPLE_BITS-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                o_we       = 1'b1;
                n_clr_addr = r_clr_addr + SAMPLE_BITS'(1);
                if (r_clr_addr == LAST_BIN) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_ADD: begin
                            o_raddr    = i_sample;
                            n_add_addr = i_sample;
                            n_state    = ST_ADD_WR;
                        end
                        MODE_FETCH: begin
                            if (r_ptr[SAMPLE_BITS]) begin
                                n_valid     = 1'b1;
                                n_found     = 1'b0;
                                n_bin_value = '0;
                                n_bin_count = '0;
                            end else begin
                                n_scan  = r_ptr;
                                n_state = ST_SCAN;
                            end
                        end
                        MODE_CLEAR: begin
                            n_clr_addr = '0;
                            n_ptr      = '0;
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD_WR: begin
                o_we    = 1'b1;
                o_waddr = r_add_addr;
                o_wdata = (i_rdata == COUNT_MAX) ? i_rdata : i_rdata + COUNT_BITS'(1);
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_rdata != '0) begin
                    n_valid     = 1'b1;
                    n_found     = 1'b1;
                    n_bin_value = r_scan[SAMPLE_BITS-1:0];
                    n_bin_count = i_rdata;
                    n_ptr       = scan_next;
                    n_state     = ST_IDLE;
                end else if (scan_next[SAMPLE_BITS]) begin
                    n_valid     = 1'b1;
                    n_found     = 1'b0;
                    n_bin_value = '0;
                    n_bin_count = '0;
                    n_ptr       = scan_next;
                    n_state     = ST_IDLE;
                end else begin
                    o_raddr = scan_next[SAMPLE_BITS-1:0];
                    n_scan  = scan_next;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_ptr      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_ptr      <= n_ptr;
            r_valid    <= n_valid;
        end
        r_scan      <= n_scan;
        r_add_addr  <= n_add_addr;
        r_found     <= n_found;
        r_bin_value <= n_bin_value;
        r_bin_count <= n_bin_count;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_found     = r_found;
    assign o_bin_value = r_bin_value;
    assign o_bin_count = r_bin_count;

    // an accepted add writes its bin back in the next cycle
    a_add_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_ADD)) |=> (o_we && (o_waddr == $past(i_sample))))
        else $error("add item not written back");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == ST_IDLE))
        else $error("result strobe outside idle");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_found) |-> (r_bin_count != '0))
        else $error("empty bin reported as found");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr[SAMPLE_BITS] |-> (r_ptr[SAMPLE_BITS-1:0] == '0))
        else $error("scan pointer past end");

endmodule

// ===== src/sample_histogram_pmf_top.sv =====
`timescale 1ns / 1ps
// Top level of the ADC sample histogram: bin store plus sequencer.
// Depends on shpmf_pkg, shpmf_bin_ram and shpmf_ctrl.
//
// Items are taken when start is high and busy is low. An add item reads its bin, then writes
// back the saturating increment in its write-back state; the bin store has registered read data.
// A fetch item scans one bin per cycle upward from the scan pointer until it meets a non-empty
// bin or passes the last bin; an exhausted pointer answers straight from idle. A fetch gives exactly one result,
// shown for one cycle with o_valid; the receiver cannot stall it. After reset and after every clear
// item a sweep over all 2^SAMPLE_BITS bins (4096 by default) zeroes the store with busy high.
module sample_histogram_pmf_top
    import shpmf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_mode,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_bin_value,
    output logic [COUNT_BITS-1:0]  o_bin_count,
    output logic                   o_found
);

    logic                   we;
    logic [SAMPLE_BITS-1:0] waddr;
    logic [COUNT_BITS-1:0]  wdata;
    logic [SAMPLE_BITS-1:0] raddr;
    logic [COUNT_BITS-1:0]  rdata;

    shpmf_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .o_bin_value (o_bin_value),
        .o_bin_count (o_bin_count),
        .o_found     (o_found),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    shpmf_bin_ram #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
